// ===== rtl/lbsm_pkg.sv =====
// Shared constants and register codes for the low battery shutdown monitor.
// Used by the channel interfaces, the blink phase divider and the top level.
// No dependencies.
`default_nettype none

package lbsm_pkg;

   // Field widths.
   localparam int PCT_W      = 7;
   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 16;
   localparam int SECONDS_W  = 8;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Operation codes of an input transaction.
   localparam logic OP_UPDATE  = 1'b0;
   localparam logic OP_CONSUME = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_WARNING_PERCENT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CRITICAL_PERCENT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RECOVERY_MARGIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CRITICAL_DEBOUNCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNTDOWN_SECONDS = 3'd4;

   // Configuration reset values.
   localparam logic [PCT_W-1:0]      WARNING_PERCENT_RST  = 7'd15;
   localparam logic [PCT_W-1:0]      CRITICAL_PERCENT_RST = 7'd5;
   localparam logic [PCT_W-1:0]      RECOVERY_MARGIN_RST  = 7'd3;
   localparam logic [DEBOUNCE_W-1:0] CRITICAL_DEBOUNCE_RST = 16'd3000;
   localparam logic [SECONDS_W-1:0]  COUNTDOWN_SECONDS_RST = 8'd30;

   // Default blink half period in milliseconds.
   localparam int unsigned BLINK_HALF_PERIOD_MS_DEFAULT = 500;

   // A countdown length of up to 255 seconds is at most 255000 ms, which fits in 18 bits.
   localparam int CD_LIMIT_W = 18;

   // Reciprocal of 1000 scaled by 2^28. Exact floor division for any 18-bit value.
   localparam int               SEC_RECIP_W = 19;
   localparam int               SEC_SHIFT   = 28;
   localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 19'd268436;

endpackage

`default_nettype wire

// ===== rtl/lbsm_req_if.sv =====
// Input channel interface: valid/ready handshake with one battery transaction.
// Depends on lbsm_pkg for field widths.
`default_nettype none

interface lbsm_req_if
   import lbsm_pkg::*;
   ();

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [PCT_W-1:0] battery_percent;
   logic             charging;
   logic [TIME_W-1:0] now_ms;

   modport source (
      output valid, opcode, battery_percent, charging, now_ms,
      input  ready
   );

   modport sink (
      input  valid, opcode, battery_percent, charging, now_ms,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/lbsm_rsp_if.sv =====
// Result channel interface: valid/ready handshake with one monitor status transaction.
// Depends on lbsm_pkg for field widths.
`default_nettype none

interface lbsm_rsp_if
   import lbsm_pkg::*;
   ();

   logic                 valid;
   logic                 ready;
   logic                 blink_phase;
   logic                 warning_flag;
   logic                 countdown_running;
   logic [SECONDS_W-1:0] seconds_left;
   logic                 poweroff_request;
   logic                 poweroff_now;

   modport source (
      output valid, blink_phase, warning_flag, countdown_running, seconds_left,
             poweroff_request, poweroff_now,
      input  ready
   );

   modport sink (
      input  valid, blink_phase, warning_flag, countdown_running, seconds_left,
             poweroff_request, poweroff_now,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/lbsm_csr_if.sv =====
// Configuration write channel interface: valid/ready with register index and data.
// Depends on lbsm_pkg for field widths.
`default_nettype none

interface lbsm_csr_if
   import lbsm_pkg::*;
   ();

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/lbsm_blink_phase.sv =====
// Blink phase: parity of now_ms divided by the blink half period, by reciprocal multiply.
// The 32x33 product is split into two registered partial products. Depends on lbsm_pkg.
`default_nettype none

module lbsm_blink_phase
   import lbsm_pkg::*;
#(
   parameter int unsigned HALF_PERIOD_MS = BLINK_HALF_PERIOD_MS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [TIME_W-1:0] now_ms,
   output logic                   phase
);

   // Reciprocal floor(2^(32+L)/H)+1 gives an exact quotient for every 32-bit dividend.
   localparam int          SHIFT_L  = $clog2(HALF_PERIOD_MS);
   localparam logic [63:0] RECIP    = ((64'd1 << (32 + SHIFT_L)) / HALF_PERIOD_MS) + 64'd1;
   localparam int          LO_W     = 17;
   localparam int          HI_W     = 16;
   localparam int          PROD_W   = TIME_W + LO_W + HI_W;
   localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
   localparam logic [HI_W-1:0] RECIP_HI = RECIP[LO_W+HI_W-1:LO_W];

   logic [TIME_W+LO_W-1:0] part_lo_ff;
   logic [TIME_W+HI_W-1:0] part_hi_ff;
   logic [PROD_W-1:0]      product;

   // Partial products are captured with the transaction.
   always_ff @(posedge clock) begin
      if (load) begin
         part_lo_ff <= {{LO_W{1'b0}}, now_ms} * {{TIME_W{1'b0}}, RECIP_LO};
         part_hi_ff <= {{HI_W{1'b0}}, now_ms} * {{TIME_W{1'b0}}, RECIP_HI};
      end
   end

   // Recombine the partials; the quotient's lowest bit sits at 32+L.
   assign product = {{HI_W{1'b0}}, part_lo_ff} + {part_hi_ff, {LO_W{1'b0}}};
   assign phase   = ~product[TIME_W + SHIFT_L];

endmodule

`default_nettype wire

// ===== rtl/low_battery_shutdown_monitor_core.sv =====
// Top level of the low battery shutdown monitor: input stage, state update, result register.
// Depends on lbsm_pkg, the three channel interfaces and lbsm_blink_phase.
`default_nettype none

// Each transaction is first held in the input stage, where the blink divider forms
// its partial products, and then passes the state update, which writes the result
// register. A new transaction is accepted every cycle while the result side keeps
// taking results; a result that waits does not stop the input stage from holding one
// more transaction. Configuration writes are always ready and take effect at once,
// and should be made only while the monitor is idle.
module low_battery_shutdown_monitor_core
   import lbsm_pkg::*;
#(
   parameter int unsigned BLINK_HALF_PERIOD_MS = BLINK_HALF_PERIOD_MS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   lbsm_req_if.sink   req_bus,
   lbsm_rsp_if.source rsp_bus,
   lbsm_csr_if.sink   csr_bus
);

   // Configuration registers.
   logic [PCT_W-1:0]      warning_percent_ff;
   logic [PCT_W-1:0]      critical_percent_ff;
   logic [PCT_W-1:0]      recovery_margin_ff;
   logic [DEBOUNCE_W-1:0] critical_debounce_ff;
   logic [SECONDS_W-1:0]  countdown_seconds_ff;

   // Input stage.
   logic              s1_valid_ff;
   logic              s1_opcode_ff;
   logic [PCT_W-1:0]  s1_pct_ff;
   logic              s1_charging_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              blink_phase;

   // Monitor state.
   logic                 blink_on_ff, blink_on_in;
   logic                 warning_on_ff, warning_on_in;
   logic                 countdown_on_ff, countdown_on_in;
   logic                 critical_pending_ff, critical_pending_in;
   logic [TIME_W-1:0]    critical_since_ff, critical_since_in;
   logic [TIME_W-1:0]    countdown_start_ff, countdown_start_in;
   logic [SECONDS_W-1:0] seconds_count_ff, seconds_count_in;
   logic                 poweroff_latched_ff, poweroff_latched_in;
   logic                 fire;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_blink_ff, out_warning_ff, out_countdown_ff;
   logic [SECONDS_W-1:0] out_seconds_ff;
   logic                 out_request_ff, out_now_ff;

   logic accept_in;
   logic advance;

   // Datapath helpers.
   logic [TIME_W-1:0]                elapsed_cd;
   logic [TIME_W-1:0]                elapsed_crit;
   logic [CD_LIMIT_W-1:0]            cd_limit;
   logic [CD_LIMIT_W+SEC_RECIP_W-1:0] sec_prod;
   logic [SECONDS_W-1:0]             elapsed_s;
   logic                             expired;
   logic                             debounced;
   logic [PCT_W:0]                   recover_level;
   logic                             recovered;
   logic                             in_warning_band;
   logic                             at_critical;

   // Handshake: the input stage moves on whenever the result register is free or drains.
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept_in     = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         warning_percent_ff   <= WARNING_PERCENT_RST;
         critical_percent_ff  <= CRITICAL_PERCENT_RST;
         recovery_margin_ff   <= RECOVERY_MARGIN_RST;
         critical_debounce_ff <= CRITICAL_DEBOUNCE_RST;
         countdown_seconds_ff <= COUNTDOWN_SECONDS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_WARNING_PERCENT:   warning_percent_ff   <= csr_bus.data[PCT_W-1:0];
            REG_CRITICAL_PERCENT:  critical_percent_ff  <= csr_bus.data[PCT_W-1:0];
            REG_RECOVERY_MARGIN:   recovery_margin_ff   <= csr_bus.data[PCT_W-1:0];
            REG_CRITICAL_DEBOUNCE: critical_debounce_ff <= csr_bus.data[DEBOUNCE_W-1:0];
            REG_COUNTDOWN_SECONDS: countdown_seconds_ff <= csr_bus.data[SECONDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_opcode_ff   <= req_bus.opcode;
         s1_pct_ff      <= req_bus.battery_percent;
         s1_charging_ff <= req_bus.charging;
         s1_now_ff      <= req_bus.now_ms;
      end
   end

   lbsm_blink_phase #(
      .HALF_PERIOD_MS (BLINK_HALF_PERIOD_MS)
   ) u_blink (
      .clock  (clock),
      .load   (accept_in),
      .now_ms (req_bus.now_ms),
      .phase  (blink_phase)
   );

   // Countdown timing: compare against the length in ms, divide by 1000 only in range.
   // The length in ms is seconds times 1024 - 32 + 8.
   assign elapsed_cd = s1_now_ff - countdown_start_ff;
   assign cd_limit   = {countdown_seconds_ff, 10'b0}
                     - {5'b0, countdown_seconds_ff, 5'b0}
                     + {7'b0, countdown_seconds_ff, 3'b0};
   assign expired    = elapsed_cd >= {{(TIME_W-CD_LIMIT_W){1'b0}}, cd_limit};
   assign sec_prod   = {{SEC_RECIP_W{1'b0}}, elapsed_cd[CD_LIMIT_W-1:0]}
                     * {{CD_LIMIT_W{1'b0}}, SEC_RECIP};
   assign elapsed_s  = sec_prod[SEC_SHIFT +: SECONDS_W];

   // Debounce and level checks.
   assign elapsed_crit    = s1_now_ff - critical_since_ff;
   assign debounced       = elapsed_crit >= {{(TIME_W-DEBOUNCE_W){1'b0}}, critical_debounce_ff};
   assign recover_level   = {1'b0, critical_percent_ff} + {1'b0, recovery_margin_ff};
   assign recovered       = {1'b0, s1_pct_ff} >= recover_level;
   assign at_critical     = s1_pct_ff <= critical_percent_ff;
   assign in_warning_band = (s1_pct_ff <= warning_percent_ff) && !at_critical;

   // Next state for the transaction in the input stage.
   always_comb begin
      logic finished;
      blink_on_in         = blink_on_ff;
      warning_on_in       = warning_on_ff;
      countdown_on_in     = countdown_on_ff;
      critical_pending_in = critical_pending_ff;
      critical_since_in   = critical_since_ff;
      countdown_start_in  = countdown_start_ff;
      seconds_count_in    = seconds_count_ff;
      poweroff_latched_in = poweroff_latched_ff;
      fire                = 1'b0;
      finished            = 1'b0;
      if (s1_opcode_ff == OP_UPDATE) begin
         blink_on_in = blink_phase;
         if (s1_charging_ff) begin
            warning_on_in       = 1'b0;
            countdown_on_in     = 1'b0;
            critical_pending_in = 1'b0;
         end else begin
            // A running countdown either cancels on recovery or keeps counting.
            if (countdown_on_ff) begin
               if (recovered) begin
                  countdown_on_in     = 1'b0;
                  critical_pending_in = 1'b0;
               end else begin
                  finished = 1'b1;
                  if (expired) begin
                     seconds_count_in    = '0;
                     poweroff_latched_in = 1'b1;
                  end else begin
                     seconds_count_in = countdown_seconds_ff - elapsed_s;
                  end
               end
            end
            // Warning band and critical debounce, also right after a cancel.
            if (!finished) begin
               warning_on_in = in_warning_band;
               if (at_critical) begin
                  if (!critical_pending_in) begin
                     critical_pending_in = 1'b1;
                     critical_since_in   = s1_now_ff;
                  end else if (debounced) begin
                     countdown_on_in     = 1'b1;
                     countdown_start_in  = s1_now_ff;
                     seconds_count_in    = countdown_seconds_ff;
                     warning_on_in       = 1'b0;
                     critical_pending_in = 1'b0;
                  end
               end else begin
                  critical_pending_in = 1'b0;
               end
            end
         end
      end else begin
         fire                = poweroff_latched_ff;
         poweroff_latched_in = 1'b0;
      end
   end

   // State registers update as the transaction leaves the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_on_ff         <= 1'b0;
         warning_on_ff       <= 1'b0;
         countdown_on_ff     <= 1'b0;
         critical_pending_ff <= 1'b0;
         critical_since_ff   <= '0;
         countdown_start_ff  <= '0;
         seconds_count_ff    <= '0;
         poweroff_latched_ff <= 1'b0;
      end else if (advance) begin
         blink_on_ff         <= blink_on_in;
         warning_on_ff       <= warning_on_in;
         countdown_on_ff     <= countdown_on_in;
         critical_pending_ff <= critical_pending_in;
         critical_since_ff   <= critical_since_in;
         countdown_start_ff  <= countdown_start_in;
         seconds_count_ff    <= seconds_count_in;
         poweroff_latched_ff <= poweroff_latched_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_blink_ff     <= blink_on_in;
         out_warning_ff   <= warning_on_in;
         out_countdown_ff <= countdown_on_in;
         out_seconds_ff   <= seconds_count_in;
         out_request_ff   <= poweroff_latched_ff;
         out_now_ff       <= fire;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.blink_phase       = out_blink_ff;
   assign rsp_bus.warning_flag      = out_warning_ff;
   assign rsp_bus.countdown_running = out_countdown_ff;
   assign rsp_bus.seconds_left      = out_seconds_ff;
   assign rsp_bus.poweroff_request  = out_request_ff;
   assign rsp_bus.poweroff_now      = out_now_ff;

endmodule

`default_nettype wire

// ===== bench/lbsm_monitor_checker.sv =====
// Checker for the low battery shutdown monitor: watches all three channels, predicts each status
// transaction and compares it with what the block returns.
// Depends on lbsm_pkg and the request, response and register write interfaces.
`default_nettype none

module lbsm_monitor_checker
   import lbsm_pkg::*;
#(
   parameter int unsigned BLINK_HALF_MS = BLINK_HALF_PERIOD_MS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   lbsm_req_if      req_bus,
   lbsm_rsp_if      rsp_bus,
   lbsm_csr_if      csr_bus,
   output int       outstanding,
   output int       error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [PCT_W-1:0]      warning_pct;
      logic [PCT_W-1:0]      critical_pct;
      logic [PCT_W-1:0]      margin_pct;
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [SECONDS_W-1:0]  countdown_len;
   } limits_type;

   typedef struct {
      logic                 blink_on;
      logic                 warning_on;
      logic                 countdown_on;
      logic                 critical_pending;
      logic [TIME_W-1:0]    critical_since;
      logic [TIME_W-1:0]    countdown_start;
      logic [SECONDS_W-1:0] seconds_count;
      logic                 poweroff_latched;
   } monitor_state_type;

   typedef struct packed {
      logic                 blink_phase;
      logic                 warning_flag;
      logic                 countdown_running;
      logic [SECONDS_W-1:0] seconds_left;
      logic                 poweroff_request;
      logic                 poweroff_now;
   } status_type;

   limits_type        limits;
   monitor_state_type mon;
   status_type        pending_status_q[$];
   int                errors;

   // Advance the monitor copy by one transaction and return the status it should report.
   function automatic status_type predict_monitor_status(input logic op,
                                                         input logic [PCT_W-1:0] pct,
                                                         input logic chg,
                                                         input logic [TIME_W-1:0] now);
      status_type        st;
      logic [TIME_W-1:0] elapsed_s;
      logic              counting;
      st.poweroff_request = mon.poweroff_latched;
      st.poweroff_now     = 1'b0;
      if (op == OP_CONSUME) begin
         st.poweroff_now      = mon.poweroff_latched;
         mon.poweroff_latched = 1'b0;
      end else begin
         mon.blink_on = ((now / BLINK_HALF_MS) & 32'd1) == 32'd0;
         if (chg) begin
            // Charging clears the warning, the countdown and the pending critical flag.
            mon.warning_on       = 1'b0;
            mon.countdown_on     = 1'b0;
            mon.critical_pending = 1'b0;
         end else begin
            counting = 1'b0;
            if (mon.countdown_on) begin
               // The recovery threshold is formed one bit wider so that it cannot wrap.
               if ({1'b0, pct} >= ({1'b0, limits.critical_pct} + {1'b0, limits.margin_pct}))
               begin
                  mon.countdown_on     = 1'b0;
                  mon.critical_pending = 1'b0;
               end else begin
                  elapsed_s = (now - mon.countdown_start) / 32'd1000;
                  if (elapsed_s >= 32'(limits.countdown_len)) begin
                     mon.seconds_count    = '0;
                     mon.poweroff_latched = 1'b1;
                  end else begin
                     mon.seconds_count = limits.countdown_len - elapsed_s[SECONDS_W-1:0];
                  end
                  counting = 1'b1;
               end
            end
            // A cancelled countdown falls through to the band checks on the same sample.
            if (!counting) begin
               mon.warning_on = (pct <= limits.warning_pct) && (pct > limits.critical_pct);
               if (pct <= limits.critical_pct) begin
                  if (!mon.critical_pending) begin
                     mon.critical_pending = 1'b1;
                     mon.critical_since   = now;
                  end else if ((now - mon.critical_since) >= 32'(limits.debounce_ms)) begin
                     mon.countdown_on     = 1'b1;
                     mon.countdown_start  = now;
                     mon.seconds_count    = limits.countdown_len;
                     mon.warning_on       = 1'b0;
                     mon.critical_pending = 1'b0;
                  end
               end else begin
                  mon.critical_pending = 1'b0;
               end
            end
         end
      end
      st.blink_phase       = mon.blink_on;
      st.warning_flag      = mon.warning_on;
      st.countdown_running = mon.countdown_on;
      st.seconds_left      = mon.seconds_count;
      return st;
   endfunction

   // Compare returned status, then record new requests and register writes.
   always @(posedge clock) begin : watch
      status_type got;
      status_type want;
      if (reset) begin
         limits.warning_pct   = WARNING_PERCENT_RST;
         limits.critical_pct  = CRITICAL_PERCENT_RST;
         limits.margin_pct    = RECOVERY_MARGIN_RST;
         limits.debounce_ms   = CRITICAL_DEBOUNCE_RST;
         limits.countdown_len = COUNTDOWN_SECONDS_RST;
         mon = '{default: '0};
         pending_status_q.delete();
         errors = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.blink_phase, rsp_bus.warning_flag, rsp_bus.countdown_running,
                    rsp_bus.seconds_left, rsp_bus.poweroff_request, rsp_bus.poweroff_now};
            if (pending_status_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("[%0t] status transaction with none outstanding: %p", $time, got);
            end else begin
               want = pending_status_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $display("[%0t] status mismatch: expected blink=%0b warn=%0b run=%0b",
                              $time, want.blink_phase, want.warning_flag,
                              want.countdown_running);
                     $display("   secs=%0d req=%0b now=%0b | got blink=%0b warn=%0b run=%0b",
                              want.seconds_left, want.poweroff_request, want.poweroff_now,
                              got.blink_phase, got.warning_flag, got.countdown_running);
                     $display("   secs=%0d req=%0b now=%0b", got.seconds_left,
                              got.poweroff_request, got.poweroff_now);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_status_q.push_back(predict_monitor_status(req_bus.opcode,
               req_bus.battery_percent, req_bus.charging, req_bus.now_ms));
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_WARNING_PERCENT:   limits.warning_pct   = csr_bus.data[PCT_W-1:0];
               REG_CRITICAL_PERCENT:  limits.critical_pct  = csr_bus.data[PCT_W-1:0];
               REG_RECOVERY_MARGIN:   limits.margin_pct    = csr_bus.data[PCT_W-1:0];
               REG_CRITICAL_DEBOUNCE: limits.debounce_ms   = csr_bus.data[DEBOUNCE_W-1:0];
               REG_COUNTDOWN_SECONDS: limits.countdown_len = csr_bus.data[SECONDS_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_status_q.size();
      error_count <= errors;
   end

endmodule

`default_nettype wire

// ===== bench/tb_low_battery_shutdown_monitor_core.sv =====
// Testbench top for the low battery shutdown monitor: clock, reset, stimulus and verdict.
// Depends on lbsm_pkg, the channel interfaces, the core and lbsm_monitor_checker.
`default_nettype none

module tb_low_battery_shutdown_monitor_core
   import lbsm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int             CLK_HALF        = 6;
   localparam int             RESET_CYCLES    = 8;
   localparam int             WATCHDOG_LIMIT  = 5000;
   localparam int             HOLD_OFF_CYCLES = 300;
   localparam int             DRAIN_CYCLES    = 6;
   localparam int             PHASE_ITEMS     = 200;
   localparam int             PHASE_COUNT     = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbsm_req_if req_ch ();
   lbsm_rsp_if rsp_ch ();
   lbsm_csr_if csr_ch ();

   int outstanding;
   int error_count;
   int idle_cycles     = 0;
   int items_sent      = 0;
   int consumes_sent   = 0;
   int results_taken   = 0;
   int poweroffs_seen  = 0;
   int csr_writes      = 0;
   int settings_used   = 0;

   // Stimulus shaping state: the sample stream and the limits it is aimed at.
   logic [TIME_W-1:0] stream_ms;
   int                level_pct;
   int                charge_left;
   int                max_step;
   int                cfg_warn;
   int                cfg_crit;
   int                cfg_margin;
   bit                sender_burst   = 1'b0;
   bit                receiver_burst = 1'b0;

   low_battery_shutdown_monitor_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   lbsm_monitor_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_bus     (csr_ch),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   // Free-running clock.
   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Watchdog on cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[low_battery_shutdown_monitor_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request transaction after a random gap and wait for it to be taken.
   task automatic send_item(input logic op, input logic [PCT_W-1:0] pct, input logic chg,
                            input logic [TIME_W-1:0] now);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.opcode          <= op;
      req_ch.battery_percent <= pct;
      req_ch.charging        <= chg;
      req_ch.now_ms          <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (op == OP_CONSUME) consumes_sent++;
   endtask

   // Wait until every predicted status transaction has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One register write transaction; valid is left high for back-to-back writes.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_writes++;
   endtask

   // Bring the block to idle and load a full set of limits.
   task automatic apply_setting(input int warn, input int crit, input int margin,
                                input int debounce, input int cd, input bit poke_unmapped);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(REG_WARNING_PERCENT, 16'(warn));
      write_reg(REG_CRITICAL_PERCENT, 16'(crit));
      write_reg(REG_RECOVERY_MARGIN, 16'(margin));
      write_reg(REG_CRITICAL_DEBOUNCE, 16'(debounce));
      write_reg(REG_COUNTDOWN_SECONDS, 16'(cd));
      if (poke_unmapped) write_reg(CSR_UNMAPPED, 16'($urandom));
      csr_ch.valid <= 1'b0;
      settings_used++;
      cfg_warn   = warn;
      cfg_crit   = crit;
      cfg_margin = margin;
      // Scale time steps so a full debounce plus countdown spans a dozen or so samples.
      max_step = (debounce + cd * 1000) / 8;
      if (max_step < 20) max_step = 20;
      if (max_step > 60000) max_step = 60000;
      level_pct   = (warn + 5 > 127) ? 127 : warn + 5;
      charge_left = 0;
   endtask

   // Mostly a plausible battery trace with random content, mixed with consumes and noise.
   task automatic send_random_item();
      int roll;
      int lo;
      int hi;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         send_item(OP_CONSUME, PCT_W'($urandom), 1'($urandom), $urandom);
      end else if (roll < 16) begin
         send_item(OP_UPDATE, PCT_W'($urandom), 1'($urandom), $urandom);
      end else begin
         stream_ms = stream_ms + $urandom_range(0, max_step);
         lo = (cfg_crit > 4) ? cfg_crit - 4 : 0;
         hi = cfg_crit + cfg_margin + 8;
         if (cfg_warn + 4 > hi) hi = cfg_warn + 4;
         if (hi > 127) hi = 127;
         if (charge_left > 0) begin
            charge_left--;
            level_pct += $urandom_range(0, 3);
         end else if ($urandom_range(0, 49) == 0) begin
            charge_left = $urandom_range(1, 4);
         end else if ($urandom_range(0, 39) == 0) begin
            level_pct = $urandom_range(lo, hi);
         end else begin
            // Slow downward drift so the trace keeps sinking into the critical band.
            level_pct += int'($urandom_range(0, 3)) - 2;
         end
         if (level_pct < 0) level_pct = 0;
         if (level_pct > 127) level_pct = 127;
         send_item(OP_UPDATE, PCT_W'(level_pct), charge_left > 0, stream_ms);
      end
   endtask

   // Result side: random stall after each status transaction, with two long hold-offs.
   initial begin : status_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            if (rsp_ch.poweroff_now) poweroffs_seen++;
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 15);
            if (results_taken == 400 || results_taken == 1000) stall = HOLD_OFF_CYCLES;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // Stimulus: directed cases, mostly at reset limits, then randomized phases.
   initial begin : stimulus
      req_ch.valid           <= 1'b0;
      req_ch.opcode          <= OP_UPDATE;
      req_ch.battery_percent <= '0;
      req_ch.charging        <= 1'b0;
      req_ch.now_ms          <= '0;
      csr_ch.valid           <= 1'b0;
      csr_ch.index           <= REG_WARNING_PERCENT;
      csr_ch.data            <= '0;
      stream_ms   = '0;
      level_pct   = 20;
      charge_left = 0;
      max_step    = 1000;
      cfg_warn    = int'(WARNING_PERCENT_RST);
      cfg_crit    = int'(CRITICAL_PERCENT_RST);
      cfg_margin  = int'(RECOVERY_MARGIN_RST);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Consume with nothing pending, then full-scale and warning-band samples.
      send_item(OP_CONSUME, 7'd127, 1'b1, 32'hFFFF_FFFF);
      send_item(OP_UPDATE, 7'd127, 1'b0, 32'd0);
      send_item(OP_UPDATE, 7'd15, 1'b0, 32'd500);
      send_item(OP_UPDATE, 7'd6, 1'b0, 32'd1000);
      // Debounce: one millisecond short, then exactly met.
      send_item(OP_UPDATE, 7'd5, 1'b0, 32'd1500);
      send_item(OP_UPDATE, 7'd5, 1'b0, 32'd4499);
      send_item(OP_UPDATE, 7'd4, 1'b0, 32'd4500);
      send_item(OP_UPDATE, 7'd7, 1'b0, 32'd10500);
      // Recovery at the threshold cancels and rechecks the warning band on the same sample.
      send_item(OP_UPDATE, 7'd8, 1'b0, 32'd11000);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'd12000);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'd15000);
      // Charging stops the countdown but keeps the seconds display.
      send_item(OP_UPDATE, 7'd0, 1'b1, 32'd16000);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'd17000);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'd20000);
      // Expiry latches the request, and it latches again after being consumed.
      send_item(OP_UPDATE, 7'd3, 1'b0, 32'd50000);
      send_item(OP_CONSUME, 7'd0, 1'b0, 32'd1);
      send_item(OP_UPDATE, 7'd3, 1'b0, 32'd51000);
      send_item(OP_CONSUME, 7'd0, 1'b0, 32'd1);
      send_item(OP_CONSUME, 7'd0, 1'b0, 32'd1);
      // Zero debounce and zero countdown length, with the timestamp wrapping.
      apply_setting(15, 5, 3, 0, 0, 1'b0);
      send_item(OP_UPDATE, 7'd0, 1'b1, 32'hFFFF_FE00);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'hFFFF_FF00);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'hFFFF_FF00);
      send_item(OP_UPDATE, 7'd0, 1'b0, 32'h0000_0100);
      send_item(OP_CONSUME, 7'd0, 1'b0, 32'h0000_0100);

      // Randomized phases, the first two at fixed low and high limit settings.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               apply_setting(0, 0, 0, 0, 1, 1'b0);
               stream_ms = 32'hFFFF_FF00;
            end
            1: begin
               apply_setting(100, 100, 100, 65535, 255, 1'b0);
               stream_ms = $urandom;
            end
            default: begin
               cfg_warn = $urandom_range(0, 100);
               apply_setting(cfg_warn,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                         : $urandom_range(0, cfg_warn),
                             $urandom_range(0, 25), $urandom_range(0, 6000),
                             $urandom_range(1, 40), phase == 3);
               stream_ms = $urandom;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once, let the pipeline empty completely before going on.
            if (phase == 1 && n == PHASE_ITEMS / 2) begin
               req_ch.valid <= 1'b0;
               wait_drained();
            end
            send_random_item();
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions (%0d consumes) under %0d limit settings (%0d writes).",
               items_sent, consumes_sent, settings_used, csr_writes);
      $display("Checked %0d status transactions, %0d of which reported a power-off.",
               results_taken, poweroffs_seen);
      if (error_count == 0 && outstanding == 0) begin
         $display("[low_battery_shutdown_monitor_core] OK");
      end else begin
         $display("[low_battery_shutdown_monitor_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
